FILE: hw/rtl/rpps_pkg.sv
// Shared types and constants for the rssi path parent selector.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package rpps_pkg;

  localparam int ADDR_W = 16;
  localparam int SUM_W  = 16;
  localparam int LINK_W = 8;
  localparam int STAT_W = 2;

  localparam logic signed [SUM_W-1:0] NO_PATH = -16'sd1000;

  localparam logic [STAT_W-1:0] STATUS_UPDATED = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_SINK    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic        [ADDR_W-1:0] neighbor_addr;
    logic signed [SUM_W-1:0]  advertised_path_rssi;
    logic signed [LINK_W-1:0] link_rssi;
  } in_t;

  typedef struct packed {
    logic        [STAT_W-1:0] status;
    logic                     parent_valid;
    logic        [ADDR_W-1:0] parent_addr;
    logic signed [SUM_W-1:0]  own_path_rssi;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic rd_en;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic last_rd;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rpps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rpps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rpps_ctrl.sv
// Sequencer for the selector: accept, scan the neighbor table, drain, finish.
// Depends on rpps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpps_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rpps_pkg::stat_t stat,
  output rpps_pkg::cmd_t       cmd
);

  import rpps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = stat.empty ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (stat.last_rd) begin
          state_next = ST_DRAIN;
        end
      end
      // last read word is compared here
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rpps_dp.sv
// Datapath: neighbor table ram, lookup and best-path scan, parent state, result register.
// Depends on rpps_pkg and rpps_ram.
`timescale 1ns / 1ps
`default_nettype none

module rpps_dp #(
  parameter int SLOTS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data,
  input  wire rpps_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rpps_pkg::out_t       out_data,
  input  wire rpps_pkg::cmd_t  cmd,
  output rpps_pkg::stat_t      stat
);

  import rpps_pkg::*;

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int ENTRY_W = ADDR_W + SUM_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SLOTS);

  function automatic logic in_window(input logic signed [SUM_W-1:0] s);
    in_window = (s > NO_PATH) && (s < 0);
  endfunction

  logic                     is_sink;
  in_t                      cur;
  logic signed [SUM_W-1:0]  new_sum;
  logic        [CNT_W-1:0]  used_count;
  logic        [IDX_W-1:0]  rd_idx;
  logic                     cmp_vld;
  logic        [IDX_W-1:0]  cmp_idx;
  logic                     hit_found;
  logic        [IDX_W-1:0]  hit_idx;
  logic                     win_found;
  logic        [ADDR_W-1:0] win_addr;
  logic signed [SUM_W-1:0]  best;
  logic        [ADDR_W-1:0] chosen_parent;
  logic                     chosen_valid;
  logic signed [SUM_W-1:0]  best_sum;

  logic        [ENTRY_W-1:0] rd_data;
  logic        [ADDR_W-1:0]  e_addr;
  logic                      e_match;
  logic signed [SUM_W-1:0]   e_sum;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sat_sum;

  logic                     miss;
  logic                     full;
  logic                     alloc;
  logic                     fin_take;
  logic                     fin_found;
  logic        [ADDR_W-1:0] fin_addr;
  logic signed [SUM_W-1:0]  fin_best;
  logic                     upd;
  logic        [ADDR_W-1:0] chosen_parent_next;
  logic                     chosen_valid_next;
  logic signed [SUM_W-1:0]  best_sum_next;
  logic                     ram_we;
  logic        [IDX_W-1:0]  ram_waddr;
  logic        [STAT_W-1:0] status_next;

  rpps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cur.neighbor_addr, new_sum}),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // saturating add of advertised sum and link rssi
  always_comb begin
    sum_wide = {in_data.advertised_path_rssi[SUM_W-1], in_data.advertised_path_rssi}
             + {{(SUM_W + 1 - LINK_W){in_data.link_rssi[LINK_W-1]}}, in_data.link_rssi};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sat_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_sum = sum_wide[SUM_W-1:0];
    end
  end

  // the entry that matches the beacon sender is scored with its new sum
  always_comb begin
    e_addr  = rd_data[ENTRY_W-1:SUM_W];
    e_match = (e_addr == cur.neighbor_addr);
    e_sum   = e_match ? new_sum : rd_data[SUM_W-1:0];
  end

  always_comb begin
    miss      = !hit_found;
    full      = miss && (used_count == FULL_COUNT);
    alloc     = miss && !full;
    // a newly allocated entry is the newest and is scored last
    fin_take  = alloc && in_window(new_sum) && (new_sum >= best);
    fin_found = win_found || fin_take;
    fin_addr  = fin_take ? cur.neighbor_addr : win_addr;
    fin_best  = fin_take ? new_sum : best;
    upd       = !full && !is_sink && fin_found;

    chosen_parent_next = upd ? fin_addr : chosen_parent;
    chosen_valid_next  = upd ? 1'b1 : chosen_valid;
    best_sum_next      = upd ? fin_best : best_sum;

    ram_we    = cmd.finish && !full;
    ram_waddr = hit_found ? hit_idx : used_count[IDX_W-1:0];

    if (full) begin
      status_next = STATUS_FULL;
    end else if (is_sink) begin
      status_next = STATUS_SINK;
    end else begin
      status_next = STATUS_UPDATED;
    end
  end

  always_comb begin
    stat.empty    = (used_count == '0);
    stat.last_rd  = ((CNT_W'(rd_idx) + CNT_W'(1)) == used_count);
    stat.out_free = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      is_sink       <= 1'b0;
      used_count    <= '0;
      chosen_parent <= '0;
      chosen_valid  <= 1'b0;
      best_sum      <= NO_PATH;
      out_valid     <= 1'b0;
      cmp_vld       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        is_sink <= cfg_wr_data;
      end
      cmp_vld <= cmd.rd_en;
      if (cmd.finish) begin
        if (alloc) begin
          used_count <= used_count + CNT_W'(1);
        end
        chosen_parent <= chosen_parent_next;
        chosen_valid  <= chosen_valid_next;
        best_sum      <= best_sum_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan and payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur       <= in_data;
      new_sum   <= sat_sum;
      rd_idx    <= '0;
      hit_found <= 1'b0;
      win_found <= 1'b0;
      best      <= NO_PATH;
    end else begin
      if (cmd.rd_en) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
      if (cmp_vld) begin
        if (e_match) begin
          hit_found <= 1'b1;
          hit_idx   <= cmp_idx;
        end
        if (in_window(e_sum) && (e_sum >= best)) begin
          best      <= e_sum;
          win_addr  <= e_addr;
          win_found <= 1'b1;
        end
      end
    end
    cmp_idx <= rd_idx;
    if (cmd.finish) begin
      out_data.status        <= status_next;
      out_data.parent_valid  <= chosen_valid_next;
      out_data.parent_addr   <= chosen_parent_next;
      out_data.own_path_rssi <= is_sink ? '0 : best_sum_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rssi_path_parent_selector.sv
// Top level of the rssi path parent selector: controller plus datapath.
// Depends on rpps_pkg, rpps_ctrl, rpps_dp (and through it rpps_ram).
//
//   port group   direction  handshake          payload
//   in           sink       in_valid/in_ready  in_data (rpps_pkg::in_t)
//   out          source     out_valid/out_ready out_data (rpps_pkg::out_t)
//   cfg          sink       cfg_wr_en          cfg_wr_data (is_sink)
//
// one word passes through these steps: accept, one table read per used
// entry through the single ram read port, a compare drain state, a finish
// state; with an empty table there is no read and no drain.
// the finish state waits while the previous result is still held.
// reset is synchronous; the table needs no clearing pass since only entries
// below the fill count are read. in_ready is high only while idle.
`timescale 1ns / 1ps
`default_nettype none

module rssi_path_parent_selector #(
  parameter int NEIGHBOR_SLOTS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_wr_en,
  input  wire logic           cfg_wr_data,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rpps_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rpps_pkg::out_t      out_data
);

  import rpps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rpps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpps_dp #(
    .SLOTS (NEIGHBOR_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/rpps_checker.sv
// Port-level checks for the rssi path parent selector, bound to the top level.
// Depends on rpps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpps_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire rpps_pkg::out_t out_data
);

  import rpps_pkg::*;

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // an accepted word keeps the input closed while it is processed
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after an accepted word");

  a_sink_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_SINK |-> out_data.own_path_rssi == '0)
    else $error("sink reports nonzero path");

  a_no_parent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.parent_valid |->
      out_data.parent_addr == '0 &&
      (out_data.own_path_rssi == NO_PATH || out_data.own_path_rssi == '0))
    else $error("parent fields set without a parent");

endmodule

bind rssi_path_parent_selector rpps_checker u_rpps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
